/* rtl/channel_mix_loudness_normalizer_unit_macros.svh */
// Assertion macros for the channel mix loudness normaliser.
// Used by the top level only; define NO_ASSERTIONS to compile them away.
`ifndef CHANNEL_MIX_LOUDNESS_NORMALIZER_UNIT_MACROS_SVH
`define CHANNEL_MIX_LOUDNESS_NORMALIZER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every edge out of reset
`define CMLN_ASSERT_HOLDS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("cmln: invariant violated");
// antecedent implies consequent in the same cycle
`define CMLN_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cmln: implication violated");
`else
`define CMLN_ASSERT_HOLDS(lbl, clk, rstn, cond)
`define CMLN_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/cmln_pkg.sv */
// Shared types and constants for the channel mix loudness normaliser.
// No dependencies; imported by the top level (cmln_ram does not use it).
`timescale 1ns / 1ps
package cmln_pkg;

    localparam int MAX_LEN_DEF      = 16384;
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_W         = 16;
    localparam int TARGET_W         = 16;
    localparam int GAIN_W           = 32;
    localparam int EPS_W            = 8;
    localparam logic [EPS_W-1:0]    EPS_STEPS    = 8'd134;
    localparam logic [TARGET_W-1:0] TARGET_RESET = 16'd3685;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic                       operation;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_channel;
        logic                       end_of_row;
    } cmln_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] norm_value;
        logic                       last_of_row;
        logic                       none_ready;
    } cmln_out_t;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_LD_WR,
        S_POP_RD,
        S_POP_MUL,
        S_POP_OUT,
        S_NONE_OUT,
        S_P_RD,
        S_P_SQ,
        S_P_ACC,
        S_M_RD,
        S_M_SQ,
        S_M_MT,
        S_M_CMP,
        S_DIV,
        S_SQRT,
        S_G_RXA,
        S_G_EPS,
        S_G_DEN,
        S_G_RR,
        S_G_FB1,
        S_G_FB2,
        S_G_DIVGO
    } cmln_state_t;

    // what the shared divider result feeds
    typedef enum logic [1:0] {
        JOB_RMS,
        JOB_RMSX,
        JOB_GAIN
    } cmln_job_t;

endpackage

/* rtl/cmln_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cmln_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/channel_mix_loudness_normalizer_unit.sv */
// Top level of the channel mix loudness normaliser: sequencer, shared
// multiplier, divider and square root. Depends on cmln_pkg, cmln_ram and
// channel_mix_loudness_normalizer_unit_macros.svh.
`timescale 1ns / 1ps
`include "channel_mix_loudness_normalizer_unit_macros.svh"

// Samples are loaded channel after channel into a per-time sum RAM; a load
// that adds to an earlier channel reads and then writes through the single
// RAM port pair. The sample flagged end_of_row of a non-empty row starts the
// gain computation, which holds in_stall high while it runs: a power sum
// pass that reads, squares and accumulates each time, an above-mean pass
// that reads, squares, scales by the row length and compares each time,
// then two or three bit-serial divides and one or two square roots through
// one shared divider and one shared square root unit, with every product
// but the epsilon term after the first square root through one shared
// registered multiplier. Each pop goes through RAM read, multiply, and
// round and saturate. Loads may be accepted while a result waits in the
// output register; a pop waits for that register to drain.
module channel_mix_loudness_normalizer_unit #(
    parameter int MAX_LEN      = cmln_pkg::MAX_LEN_DEF,
    parameter int MAX_CHANNELS = cmln_pkg::MAX_CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  cmln_pkg::cmln_in_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output cmln_pkg::cmln_out_t                out_data,
    input  logic                               cfg_write_en,
    input  logic [cmln_pkg::TARGET_W-1:0]      cfg_write_data
);

    import cmln_pkg::*;

    // derived widths
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_CHANNELS);
    localparam int MAG_W  = SUM_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int PW     = SQ_W + LEN_W;
    localparam int R_W    = MAG_W + 12;
    localparam int RPE_W  = R_W + 1;
    localparam int AAC_W  = 2 * TARGET_W + CNT_W;
    localparam int NUM_A  = PW + 24;
    localparam int NUM_B  = AAC_W + 36;
    localparam int NW     = (NUM_A > NUM_B) ? NUM_A : NUM_B;
    localparam int DEN_A  = 2 * RPE_W;
    localparam int DEN_B  = R_W + TARGET_W + 12;
    localparam int DW     = (DEN_A > DEN_B) ? DEN_A : DEN_B;
    localparam int MA_T   = (SQ_W > RPE_W) ? SQ_W : RPE_W;
    localparam int MA_W   = (MA_T > 2 * TARGET_W) ? MA_T : 2 * TARGET_W;
    localparam int MB_T   = (LEN_W > RPE_W) ? LEN_W : RPE_W;
    localparam int MB_W   = (MB_T > GAIN_W) ? MB_T : GAIN_W;
    localparam int PR_W   = MA_W + MB_W;
    localparam int RM_W   = PR_W - 17;
    localparam int SR_W   = 2 * R_W;
    localparam int IT_W   = $clog2(NW + 1);

    // control state
    cmln_state_t            state_reg, state_next;
    cmln_job_t              job_reg, job_next;
    logic [IT_W-1:0]        cnt_reg, cnt_next;
    logic [LEN_W-1:0]       ti_reg, ti_next;
    logic [LEN_W-1:0]       rl_reg, rl_next;
    logic [CNT_W-1:0]       cc_reg, cc_next;
    logic [LEN_W-1:0]       ri_reg, ri_next;
    logic                   ready_reg, ready_next;
    logic                   calc_pend_reg, calc_pend_next;
    logic                   out_valid_reg, out_valid_next;
    logic [TARGET_W-1:0]    target_reg, target_next;
    logic [GAIN_W-1:0]      gain_reg, gain_next;
    logic [LEN_W-1:0]       idx_reg, idx_next;
    logic [LEN_W-1:0]       n_reg, n_next;

    // datapath
    logic [CNT_W-1:0]       calc_c_reg, calc_c_next;
    logic [ADDR_W-1:0]      ld_addr_reg, ld_addr_next;
    logic signed [SUM_W-1:0] ld_sample_reg, ld_sample_next;
    logic [PW-1:0]          p_reg, p_next;
    logic [PW-1:0]          pm_reg, pm_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [PR_W-1:0]        prod_reg, prod_next;
    logic [RPE_W-1:0]       rpe_reg, rpe_next;
    logic [R_W-1:0]         rx_reg, rx_next;
    logic [DW-1:0]          gtmp_reg, gtmp_next;
    logic [DW-1:0]          den_reg, den_next;
    logic [NW-1:0]          num_reg, num_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [NW-1:0]          q_reg, q_next;
    logic [SR_W-1:0]        sv_reg, sv_next;
    logic [SR_W-1:0]        sr_reg, sr_next;
    logic [SR_W-1:0]        sbit_reg, sbit_next;
    logic                   sign_reg, sign_next;
    cmln_out_t              out_data_reg, out_data_next;

    // combinational helpers
    logic                   in_fire;
    logic                   out_free;
    logic                   avail;
    logic                   wr_ok;
    logic [LEN_W-1:0]       ti_inc;
    logic [CNT_W-1:0]       cc_inc;
    logic [LEN_W-1:0]       rl_new;
    logic [MA_W-1:0]        mul_a;
    logic [MB_W-1:0]        mul_b;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [SUM_W-1:0]       ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [SUM_W-1:0]       ram_rdata;
    logic [MAG_W-1:0]       mag_rd;
    logic [DW:0]            div_remx;
    logic                   div_ge;
    logic [SR_W:0]          sqrt_sum;
    logic                   sqrt_ge;
    logic [PR_W-1:0]        rnd;
    logic [RM_W-1:0]        rmag;
    logic [SAMPLE_W-1:0]    sat_val;
    logic                   idx_last;
    logic                   above;
    logic [LEN_W-1:0]       n_upd;

    // per-time sum store
    cmln_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign avail     = ready_reg && (ri_reg < rl_reg);
    assign idx_last  = (idx_reg + 1'b1 == rl_reg);

    // load bookkeeping
    assign wr_ok  = (ti_reg < LEN_W'(MAX_LEN)) && (cc_reg < CNT_W'(MAX_CHANNELS));
    assign ti_inc = (ti_reg < LEN_W'(MAX_LEN)) ? ti_reg + 1'b1 : ti_reg;
    assign cc_inc = (cc_reg < CNT_W'(MAX_CHANNELS)) ? cc_reg + 1'b1 : cc_reg;
    assign rl_new = (cc_reg == '0) ? ti_inc : rl_reg;

    // magnitude of the word read from the store
    assign mag_rd = ram_rdata[SUM_W-1] ? MAG_W'(~ram_rdata + 1'b1) : MAG_W'(ram_rdata);

    // divider step
    assign div_remx = {rem_reg, num_reg[NW-1]};
    assign div_ge   = (div_remx >= {1'b0, den_reg});

    // square root step
    assign sqrt_sum = {1'b0, sr_reg} + {1'b0, sbit_reg};
    assign sqrt_ge  = ({1'b0, sv_reg} >= sqrt_sum);

    // mask test result for the above-mean pass
    assign above = (prod_reg > PR_W'(p_reg));
    assign n_upd = above ? n_reg + 1'b1 : n_reg;

    // rounding and saturation of a popped sample
    assign rnd  = prod_reg + PR_W'(65536);
    assign rmag = rnd[PR_W-1:17];
    always_comb
    begin
        if (!sign_reg)
        begin
            sat_val = (rmag > RM_W'(32767)) ? 16'h7FFF : rmag[SAMPLE_W-1:0];
        end
        else
        begin
            sat_val = (rmag > RM_W'(32768)) ? 16'h8000 : (~rmag[SAMPLE_W-1:0] + 1'b1);
        end
    end

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_P_SQ, S_M_SQ:
            begin
                mul_a = MA_W'(mag_rd);
                mul_b = MB_W'(mag_rd);
            end
            S_POP_MUL:
            begin
                mul_a = MA_W'(mag_rd);
                mul_b = MB_W'(gain_reg);
            end
            S_M_MT:
            begin
                mul_a = MA_W'(prod_reg[SQ_W-1:0]);
                mul_b = MB_W'(rl_reg);
            end
            S_G_RXA:
            begin
                mul_a = MA_W'(rx_reg);
                mul_b = MB_W'(target_reg);
            end
            S_G_EPS:
            begin
                mul_a = MA_W'(EPS_STEPS);
                mul_b = MB_W'(rpe_reg);
            end
            S_G_DEN, S_G_FB1:
            begin
                mul_a = MA_W'(target_reg);
                mul_b = MB_W'(target_reg);
            end
            S_G_RR:
            begin
                mul_a = MA_W'(rpe_reg);
                mul_b = MB_W'(rpe_reg);
            end
            S_G_FB2:
            begin
                mul_a = MA_W'(prod_reg[2*TARGET_W-1:0]);
                mul_b = MB_W'(calc_c_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product held while a popped sample waits for the output register
    assign prod_next = (state_reg == S_POP_OUT) ? prod_reg : PR_W'(mul_a) * PR_W'(mul_b);

    // RAM port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ti_reg[ADDR_W-1:0];
        ram_wdata = SUM_W'(ld_sample_reg);
        ram_raddr = ti_reg[ADDR_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                ram_we    = in_fire && (in_data.operation == OP_LOAD) && wr_ok
                            && (cc_reg == '0);
                ram_wdata = SUM_W'(in_data.sample);
            end
            S_LD_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ld_addr_reg;
                ram_wdata = SUM_W'($signed(ram_rdata) + ld_sample_reg);
            end
            S_POP_RD:
            begin
                ram_raddr = ri_reg[ADDR_W-1:0];
            end
            S_P_RD, S_M_RD:
            begin
                ram_raddr = idx_reg[ADDR_W-1:0];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer: next state and register updates
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        cnt_next       = cnt_reg;
        ti_next        = ti_reg;
        rl_next        = rl_reg;
        cc_next        = cc_reg;
        ri_next        = ri_reg;
        ready_next     = ready_reg;
        calc_pend_next = calc_pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        target_next    = cfg_write_en ? cfg_write_data : target_reg;
        gain_next      = gain_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        calc_c_next    = calc_c_reg;
        ld_addr_next   = ld_addr_reg;
        ld_sample_next = ld_sample_reg;
        p_next         = p_reg;
        pm_next        = pm_reg;
        sq_next        = sq_reg;
        rpe_next       = rpe_reg;
        rx_next        = rx_reg;
        gtmp_next      = gtmp_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        sv_next        = sv_reg;
        sr_next        = sr_reg;
        sbit_next      = sbit_reg;
        sign_next      = sign_reg;
        out_data_next  = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_data.operation == OP_POP)
                begin
                    state_next = avail ? S_POP_RD : S_NONE_OUT;
                end
                else if (in_fire)
                begin
                    ready_next     = 1'b0;
                    ld_addr_next   = ti_reg[ADDR_W-1:0];
                    ld_sample_next = SUM_W'(in_data.sample);
                    ti_next        = ti_inc;
                    if (in_data.end_of_channel || in_data.end_of_row)
                    begin
                        rl_next = rl_new;
                        cc_next = cc_inc;
                        ti_next = '0;
                    end
                    // compute set-up for the end of a row
                    calc_pend_next = in_data.end_of_row && (rl_new != '0);
                    calc_c_next    = cc_inc;
                    idx_next       = '0;
                    p_next         = '0;
                    pm_next        = '0;
                    n_next         = '0;
                    if (in_data.end_of_row)
                    begin
                        cc_next = '0;
                        ti_next = '0;
                    end
                    if (wr_ok && cc_reg != '0 && ti_reg < rl_reg)
                    begin
                        state_next = S_LD_WR;
                    end
                    else if (in_data.end_of_row && rl_new != '0)
                    begin
                        state_next = S_P_RD;
                    end
                end
            end

            // add to the sum of earlier channels
            S_LD_WR:
            begin
                state_next = calc_pend_reg ? S_P_RD : S_IDLE;
            end

            // readout
            S_POP_RD:
            begin
                state_next = S_POP_MUL;
            end
            S_POP_MUL:
            begin
                sign_next  = ram_rdata[SUM_W-1];
                state_next = S_POP_OUT;
            end
            S_POP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.norm_value  = sat_val;
                    out_data_next.last_of_row = (ri_reg + 1'b1 == rl_reg);
                    out_data_next.none_ready  = 1'b0;
                    ri_next                   = ri_reg + 1'b1;
                    if (ri_reg + 1'b1 == rl_reg)
                    begin
                        ready_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_NONE_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.norm_value  = '0;
                    out_data_next.last_of_row = 1'b0;
                    out_data_next.none_ready  = 1'b1;
                    state_next                = S_IDLE;
                end
            end

            // pass one: power sum
            S_P_RD:
            begin
                calc_pend_next = 1'b0;
                state_next     = S_P_SQ;
            end
            S_P_SQ:
            begin
                state_next = S_P_ACC;
            end
            S_P_ACC:
            begin
                p_next = p_reg + PW'(prod_reg[SQ_W-1:0]);
                if (idx_last)
                begin
                    idx_next   = '0;
                    num_next   = NW'({p_next, 24'b0});
                    den_next   = DW'(rl_reg);
                    rem_next   = '0;
                    q_next     = '0;
                    cnt_next   = IT_W'(NW);
                    job_next   = JOB_RMS;
                    state_next = S_DIV;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_P_RD;
                end
            end

            // pass two: power of the times above mean power
            S_M_RD:
            begin
                state_next = S_M_SQ;
            end
            S_M_SQ:
            begin
                state_next = S_M_MT;
            end
            S_M_MT:
            begin
                sq_next    = prod_reg[SQ_W-1:0];
                state_next = S_M_CMP;
            end
            S_M_CMP:
            begin
                if (above)
                begin
                    pm_next = pm_reg + PW'(sq_reg);
                end
                n_next = n_upd;
                if (idx_last)
                begin
                    idx_next = '0;
                    if (n_upd != '0)
                    begin
                        num_next   = NW'({pm_next, 24'b0});
                        den_next   = DW'(n_upd);
                        rem_next   = '0;
                        q_next     = '0;
                        cnt_next   = IT_W'(NW);
                        job_next   = JOB_RMSX;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_G_RR;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_M_RD;
                end
            end

            // shared restoring divider, one quotient bit a cycle
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    if (job_reg == JOB_GAIN)
                    begin
                        gain_next  = (|q_reg[NW-1:GAIN_W]) ? '1 : q_reg[GAIN_W-1:0];
                        ri_next    = '0;
                        ready_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sv_next    = q_reg[SR_W-1:0];
                        sr_next    = '0;
                        sbit_next  = SR_W'(1) << (SR_W - 2);
                        cnt_next   = IT_W'(R_W);
                        state_next = S_SQRT;
                    end
                end
                else
                begin
                    rem_next = div_ge ? DW'(div_remx - {1'b0, den_reg}) : div_remx[DW-1:0];
                    q_next   = {q_reg[NW-2:0], div_ge};
                    num_next = {num_reg[NW-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            // shared square root, one result bit a cycle
            S_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    if (job_reg == JOB_RMS)
                    begin
                        rpe_next   = RPE_W'(sr_reg[R_W-1:0])
                                     + RPE_W'(EPS_STEPS) * RPE_W'(calc_c_reg);
                        idx_next   = '0;
                        state_next = S_M_RD;
                    end
                    else
                    begin
                        rx_next    = sr_reg[R_W-1:0];
                        state_next = S_G_RXA;
                    end
                end
                else
                begin
                    if (sqrt_ge)
                    begin
                        sv_next = SR_W'({1'b0, sv_reg} - sqrt_sum);
                        sr_next = (sr_reg >> 1) + sbit_reg;
                    end
                    else
                    begin
                        sr_next = sr_reg >> 1;
                    end
                    sbit_next = sbit_reg >> 2;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end

            // masked gain denominator
            S_G_RXA:
            begin
                state_next = S_G_EPS;
            end
            S_G_EPS:
            begin
                gtmp_next  = DW'({prod_reg[R_W+TARGET_W-1:0], 11'b0});
                state_next = S_G_DEN;
            end
            S_G_DEN:
            begin
                den_next   = gtmp_reg + DW'(prod_reg[EPS_W+RPE_W-1:0]);
                state_next = S_G_DIVGO;
            end

            // fallback gain denominator
            S_G_RR:
            begin
                state_next = S_G_FB1;
            end
            S_G_FB1:
            begin
                den_next   = DW'(prod_reg[2*RPE_W-1:0]);
                state_next = S_G_FB2;
            end
            S_G_FB2:
            begin
                state_next = S_G_DIVGO;
            end

            // final divide of the squared target
            S_G_DIVGO:
            begin
                num_next   = NW'({prod_reg[AAC_W-1:0], 36'b0});
                rem_next   = '0;
                q_next     = '0;
                cnt_next   = IT_W'(NW);
                job_next   = JOB_GAIN;
                state_next = S_DIV;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= JOB_RMS;
            cnt_reg       <= '0;
            ti_reg        <= '0;
            rl_reg        <= '0;
            cc_reg        <= '0;
            ri_reg        <= '0;
            ready_reg     <= 1'b0;
            calc_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            target_reg    <= TARGET_RESET;
            gain_reg      <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            cnt_reg       <= cnt_next;
            ti_reg        <= ti_next;
            rl_reg        <= rl_next;
            cc_reg        <= cc_next;
            ri_reg        <= ri_next;
            ready_reg     <= ready_next;
            calc_pend_reg <= calc_pend_next;
            out_valid_reg <= out_valid_next;
            target_reg    <= target_next;
            gain_reg      <= gain_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        calc_c_reg    <= calc_c_next;
        ld_addr_reg   <= ld_addr_next;
        ld_sample_reg <= ld_sample_next;
        p_reg         <= p_next;
        pm_reg        <= pm_next;
        sq_reg        <= sq_next;
        prod_reg      <= prod_next;
        rpe_reg       <= rpe_next;
        rx_reg        <= rx_next;
        gtmp_reg      <= gtmp_next;
        den_reg       <= den_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        sv_reg        <= sv_next;
        sr_reg        <= sr_next;
        sbit_reg      <= sbit_next;
        sign_reg      <= sign_next;
        out_data_reg  <= out_data_next;
    end

    // checks
    `CMLN_ASSERT_IMPLIES(a_ready_in_row, clk, rst_n, ready_reg, ri_reg < rl_reg)
    `CMLN_ASSERT_HOLDS(a_counts_bounded, clk, rst_n, (ti_reg <= LEN_W'(MAX_LEN)) && (cc_reg <= CNT_W'(MAX_CHANNELS)))
    `CMLN_ASSERT_IMPLIES(a_ready_start, clk, rst_n, $rose(ready_reg), ri_reg == '0 && rl_reg != '0)

endmodule
